@@ rtl/core/clx_pkg.sv @@
// Package for the C subset lexer: item types, token codes, keyword and punctuator tables.
// Used by clx_front, clx_back, the top level and the testbench. Depends on nothing.
`default_nettype none
package clx_pkg;

    localparam int KW_MAX_DEFAULT      = 7;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int KW_TEXT_MAX         = 7;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [5:0] token_code;
        logic [7:0] char_value;
        logic       last;
    } t_out;

    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_LIT   = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    localparam logic [5:0] TK_IDENT   = 6'd0;
    localparam logic [5:0] TK_INT     = 6'd1;
    localparam logic [5:0] TK_VOID    = 6'd2;
    localparam logic [5:0] TK_IF      = 6'd3;
    localparam logic [5:0] TK_ELSE    = 6'd4;
    localparam logic [5:0] TK_WHILE   = 6'd5;
    localparam logic [5:0] TK_FOR     = 6'd6;
    localparam logic [5:0] TK_RETURN  = 6'd7;
    localparam logic [5:0] TK_INCLUDE = 6'd8;
    localparam logic [5:0] TK_STRING  = 6'd9;
    localparam logic [5:0] TK_CHAR    = 6'd10;
    localparam logic [5:0] TK_HASH    = 6'd11;
    localparam logic [5:0] TK_BANG    = 6'd25;

    localparam logic [1:0] OP_BANG = 2'd0;
    localparam logic [1:0] OP_LT   = 2'd1;
    localparam logic [1:0] OP_GT   = 2'd2;
    localparam logic [1:0] OP_EQ   = 2'd3;

    // Width of one queue entry for a given word buffer length.
    function automatic int cmd_bits(input int k);
        return (k + 8) + 8 * k + 8 + 5 * 6 + 1;
    endfunction

    // First seven buffered bytes, byte 0 in the top byte.
    function automatic logic [5:0] kw_lookup(input logic [8*KW_TEXT_MAX-1:0] w,
                                             input logic [4:0] len);
        logic [5:0] code;
        code = TK_IDENT;
        case (len)
            5'd2: if (w[55:40] == "if") code = TK_IF;
            5'd3: begin
                if (w[55:32] == "int") code = TK_INT;
                else if (w[55:32] == "for") code = TK_FOR;
            end
            5'd4: begin
                if (w[55:24] == "void") code = TK_VOID;
                else if (w[55:24] == "else") code = TK_ELSE;
            end
            5'd5: if (w[55:16] == "while") code = TK_WHILE;
            5'd6: if (w[55:8] == "return") code = TK_RETURN;
            5'd7: if (w == "include") code = TK_INCLUDE;
            default: code = TK_IDENT;
        endcase
        return code;
    endfunction

    // Single-byte punctuators; TK_IDENT means not one of them.
    function automatic logic [5:0] punct_code(input logic [7:0] c);
        logic [5:0] code;
        unique case (c)
            "(":     code = 6'd12;
            ")":     code = 6'd13;
            "[":     code = 6'd14;
            "]":     code = 6'd15;
            "{":     code = 6'd16;
            "}":     code = 6'd17;
            ";":     code = 6'd18;
            ",":     code = 6'd19;
            ".":     code = 6'd20;
            "+":     code = 6'd21;
            "-":     code = 6'd22;
            "*":     code = 6'd23;
            "/":     code = 6'd24;
            default: code = TK_IDENT;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/clx_fifo.sv @@
// Short queue of result bundles between the lexer front and back.
// Plain register FIFO, no package dependency.
`default_nettype none
module clx_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic      [W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wr <= r_wr + 1'b1;
            if (pop_ok)  r_rd <= r_rd + 1'b1;
            if (push_ok && !pop_ok)      r_cnt <= r_cnt + 1'b1;
            else if (pop_ok && !push_ok) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr] <= i_data;
    end
endmodule
`default_nettype wire

@@ rtl/core/clx_front.sv @@
// Lexer front: accepts source bytes, runs the scanner state and builds one
// result bundle per byte. Depends on clx_pkg.
`default_nettype none
module clx_front #(
    parameter int KEYWORD_MAX_LEN = clx_pkg::KW_MAX_DEFAULT,
    parameter int CW              = clx_pkg::cmd_bits(clx_pkg::KW_MAX_DEFAULT)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire clx_pkg::t_in   i_in_data,
    output logic                o_in_stall,
    input  wire logic           i_full,
    output logic                o_push,
    output logic [CW-1:0]       o_cmd
);
    import clx_pkg::*;

    localparam int K  = KEYWORD_MAX_LEN;
    localparam int NS = K + 8;
    localparam int LW = $clog2(K + 1);
    localparam int IW = $clog2(K);

    localparam int S_TOK0  = 0;
    localparam int S_HASH0 = 1;
    localparam int S_DUMP  = 2;
    localparam int S_LITC  = K + 2;
    localparam int S_TOK1  = K + 3;
    localparam int S_HASH1 = K + 4;
    localparam int S_TOK2  = K + 5;
    localparam int S_TOK3  = K + 6;
    localparam int S_HASH2 = K + 7;

    typedef enum logic [2:0] {
        M_IDLE, M_WORD, M_STRING, M_CHARVAL, M_CHARCLOSE, M_OPER
    } t_mode;

    typedef struct packed {
        t_mode         mode;
        logic [LW-1:0] len;
        logic          ovf;
        logic [1:0]    op;
        logic          hash;
        logic          incl;
        logic          hdr;
    } t_st;

    typedef struct packed {
        logic [NS-1:0]     vld;
        logic [K-1:0][7:0] wbuf;
        logic [7:0]        ch;
        logic [5:0]        tok0;
        logic [5:0]        litc;
        logic [5:0]        tok1;
        logic [5:0]        tok2;
        logic [5:0]        tok3;
        logic              tok2_err;
    } t_cmd;

    t_st               r_st;
    t_st               n_st;
    logic [K-1:0][7:0] r_buf;
    logic [K-1:0][7:0] n_buf;
    t_cmd              cmd;
    logic              accept;

    // End the word: keyword, include, or identifier (literals first unless spilled).
    function automatic void fin_word(inout t_st s, inout t_cmd m);
        logic [8*KW_TEXT_MAX-1:0] w;
        logic [5:0]               kw;
        for (int j = 0; j < KW_TEXT_MAX; j++) begin
            w[8*(KW_TEXT_MAX-j)-1 -: 8] = m.wbuf[j];
        end
        kw = kw_lookup(w, 5'(s.len));
        m.vld[S_TOK1] = 1'b1;
        if (s.ovf) begin
            m.tok1 = TK_IDENT;
            s.incl = 1'b0;
        end else if (kw == TK_INCLUDE && s.hash) begin
            s.hash = 1'b0;
            m.tok1 = TK_INCLUDE;
            s.incl = 1'b1;
        end else begin
            if (s.hash) begin
                m.vld[S_HASH0] = 1'b1;
                s.hash = 1'b0;
            end
            s.incl = 1'b0;
            if (kw != TK_IDENT && kw != TK_INCLUDE) begin
                m.tok1 = kw;
            end else begin
                m.tok1 = TK_IDENT;
                for (int j = 0; j < K; j++) begin
                    if (LW'(j) < s.len) m.vld[S_DUMP + j] = 1'b1;
                end
            end
        end
        s.len  = '0;
        s.ovf  = 1'b0;
        s.mode = M_IDLE;
    endfunction

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;
    assign o_push     = accept && (cmd.vld != '0);
    assign o_cmd      = cmd;

    always_comb begin
        t_st        s;
        t_cmd       m;
        logic [7:0] c;
        logic [5:0] pc;
        logic       alnum;
        logic       do_idle;
        s       = r_st;
        m       = '0;
        m.wbuf  = r_buf;
        c       = i_in_data.char_in;
        m.ch    = c;
        pc      = punct_code(c);
        do_idle = 1'b0;
        alnum   = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");

        unique case (s.mode)
            M_WORD: begin
                if (alnum || c == "_") begin
                    if (s.ovf) begin
                        m.vld[S_LITC] = 1'b1;
                        m.litc        = TK_IDENT;
                    end else if (s.len < LW'(K)) begin
                        m.wbuf[s.len[IW-1:0]] = c;
                        s.len = s.len + 1'b1;
                    end else begin
                        // word too long for a keyword: spill it as literals
                        if (s.hash) begin
                            m.vld[S_HASH0] = 1'b1;
                            s.hash = 1'b0;
                            s.incl = 1'b0;
                        end
                        m.vld[S_DUMP +: K] = '1;
                        m.vld[S_LITC]      = 1'b1;
                        m.litc             = TK_IDENT;
                        s.ovf              = 1'b1;
                    end
                end else begin
                    fin_word(s, m);
                    do_idle = 1'b1;
                end
            end
            M_STRING: begin
                if (c == "\"") begin
                    m.vld[S_TOK1] = 1'b1;
                    m.tok1        = TK_STRING;
                    s.incl        = 1'b0;
                    s.mode        = M_IDLE;
                end else begin
                    m.vld[S_LITC] = 1'b1;
                    m.litc        = TK_STRING;
                end
            end
            M_CHARVAL: begin
                m.vld[S_LITC] = 1'b1;
                m.litc        = TK_CHAR;
                m.vld[S_TOK1] = 1'b1;
                m.tok1        = TK_CHAR;
                s.incl        = 1'b0;
                s.mode        = M_CHARCLOSE;
            end
            M_CHARCLOSE: s.mode = M_IDLE;
            M_OPER: begin
                s.incl = 1'b0;
                s.mode = M_IDLE;
                if (c == "=") begin
                    m.vld[S_TOK1] = 1'b1;
                    m.tok1        = TK_BANG + {3'b000, s.op, 1'b1};
                end else begin
                    m.vld[S_TOK0] = 1'b1;
                    m.tok0        = TK_BANG + {3'b000, s.op, 1'b0};
                    do_idle       = 1'b1;
                end
            end
            M_IDLE: do_idle = 1'b1;
        endcase

        if (do_idle) begin
            s.mode = M_IDLE;
            if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
                s.mode = M_IDLE;
            end else if (alnum) begin
                s.mode    = M_WORD;
                s.ovf     = 1'b0;
                m.wbuf[0] = c;
                s.len     = LW'(1);
            end else begin
                if (s.hash) begin
                    m.vld[S_HASH1] = 1'b1;
                    s.hash = 1'b0;
                    s.incl = 1'b0;
                end
                if (c == "#") begin
                    s.hash = 1'b1;
                end else if (pc != TK_IDENT) begin
                    m.vld[S_TOK2] = 1'b1;
                    m.tok2        = pc;
                    s.incl        = 1'b0;
                end else if (c == "!") begin
                    s.op   = OP_BANG;
                    s.mode = M_OPER;
                end else if (c == "<") begin
                    // drop the opening bracket of an include header
                    if (s.incl) begin
                        s.incl = 1'b0;
                        s.hdr  = 1'b1;
                    end else begin
                        s.op   = OP_LT;
                        s.mode = M_OPER;
                    end
                end else if (c == ">") begin
                    if (s.hdr) begin
                        s.hdr = 1'b0;
                    end else begin
                        s.op   = OP_GT;
                        s.mode = M_OPER;
                    end
                end else if (c == "=") begin
                    s.op   = OP_EQ;
                    s.mode = M_OPER;
                end else if (c == "\"") begin
                    s.mode = M_STRING;
                end else if (c == "'") begin
                    s.mode = M_CHARVAL;
                end else begin
                    m.vld[S_TOK2] = 1'b1;
                    m.tok2        = TK_IDENT;
                    m.tok2_err    = 1'b1;
                end
            end
        end

        if (i_in_data.end_of_input) begin
            unique case (s.mode)
                M_WORD: fin_word(s, m);
                M_STRING: begin
                    m.vld[S_TOK3] = 1'b1;
                    m.tok3        = TK_STRING;
                end
                M_CHARVAL: begin
                    m.vld[S_TOK3] = 1'b1;
                    m.tok3        = TK_CHAR;
                end
                M_OPER: begin
                    m.vld[S_TOK3] = 1'b1;
                    m.tok3        = TK_BANG + {3'b000, s.op, 1'b0};
                end
                M_IDLE, M_CHARCLOSE: s.mode = M_IDLE;
            endcase
            if (s.hash) begin
                m.vld[S_HASH2] = 1'b1;
                s.hash = 1'b0;
            end
            s.mode = M_IDLE;
            s.len  = '0;
            s.ovf  = 1'b0;
            s.op   = OP_BANG;
            s.incl = 1'b0;
            s.hdr  = 1'b0;
        end

        n_st  = s;
        n_buf = m.wbuf;
        cmd   = m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode <= M_IDLE;
            r_st.len  <= '0;
            r_st.ovf  <= 1'b0;
            r_st.op   <= OP_BANG;
            r_st.hash <= 1'b0;
            r_st.incl <= 1'b0;
            r_st.hdr  <= 1'b0;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_buf <= n_buf;
    end
endmodule
`default_nettype wire

@@ rtl/core/clx_back.sv @@
// Lexer back: takes result bundles from the queue and sends their items
// out one per cycle while i_out_stall is low, through an output register. Depends on clx_pkg.
`default_nettype none
module clx_back #(
    parameter int KEYWORD_MAX_LEN = clx_pkg::KW_MAX_DEFAULT,
    parameter int CW              = clx_pkg::cmd_bits(clx_pkg::KW_MAX_DEFAULT)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_vld,
    input  wire logic [CW-1:0]  i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output clx_pkg::t_out       o_out_data
);
    import clx_pkg::*;

    localparam int K  = KEYWORD_MAX_LEN;
    localparam int NS = K + 8;
    localparam int SW = $clog2(NS);
    localparam int IW = $clog2(K);

    localparam int S_TOK0  = 0;
    localparam int S_HASH0 = 1;
    localparam int S_DUMP  = 2;
    localparam int S_LITC  = K + 2;
    localparam int S_TOK1  = K + 3;
    localparam int S_HASH1 = K + 4;
    localparam int S_TOK2  = K + 5;
    localparam int S_TOK3  = K + 6;

    typedef struct packed {
        logic [NS-1:0]     vld;
        logic [K-1:0][7:0] wbuf;
        logic [7:0]        ch;
        logic [5:0]        tok0;
        logic [5:0]        litc;
        logic [5:0]        tok1;
        logic [5:0]        tok2;
        logic [5:0]        tok3;
        logic              tok2_err;
    } t_cmd;

    t_cmd          r_cur;
    t_cmd          head;
    logic [NS-1:0] r_rem;
    logic [NS-1:0] sel;
    logic [NS-1:0] rem_after;
    logic [SW-1:0] idx;
    logic [IW-1:0] dix;
    logic          r_ovalid;
    t_out          r_out;
    t_out          item;
    logic          out_load;
    logic          adv;

    assign head      = i_cmd;
    assign sel       = r_rem & (~r_rem + 1'b1);
    assign rem_after = r_rem & ~sel;
    assign out_load  = !r_ovalid || !i_out_stall;
    assign adv       = (r_rem != '0) && out_load;
    assign o_pop     = i_cmd_vld && ((r_rem == '0) || (adv && rem_after == '0));
    assign dix       = IW'(idx - SW'(S_DUMP));

    always_comb begin
        idx = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (r_rem[i]) idx = SW'(i);
        end
    end

    always_comb begin
        item.item_kind  = KIND_TOKEN;
        item.token_code = TK_HASH;
        item.char_value = 8'd0;
        item.last       = (rem_after == '0);
        if (idx == SW'(S_TOK0)) begin
            item.token_code = r_cur.tok0;
        end else if (idx == SW'(S_HASH0)) begin
            item.token_code = TK_HASH;
        end else if (idx < SW'(S_LITC)) begin
            item.item_kind  = KIND_LIT;
            item.token_code = TK_IDENT;
            item.char_value = r_cur.wbuf[dix];
        end else if (idx == SW'(S_LITC)) begin
            item.item_kind  = KIND_LIT;
            item.token_code = r_cur.litc;
            item.char_value = r_cur.ch;
        end else if (idx == SW'(S_TOK1)) begin
            item.token_code = r_cur.tok1;
        end else if (idx == SW'(S_HASH1)) begin
            item.token_code = TK_HASH;
        end else if (idx == SW'(S_TOK2)) begin
            item.token_code = r_cur.tok2;
            if (r_cur.tok2_err) begin
                item.item_kind  = KIND_ERR;
                item.char_value = r_cur.ch;
            end
        end else if (idx == SW'(S_TOK3)) begin
            item.token_code = r_cur.tok3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop)    r_rem    <= head.vld;
            else if (adv) r_rem    <= rem_after;
            if (out_load) r_ovalid <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cur <= head;
        if (adv)   r_out <= item;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

@@ rtl/core/c_subset_lexer.sv @@
// Top level of the C subset lexer: front scanner, bundle queue, item sender.
// Depends on clx_pkg, clx_front, clx_fifo and clx_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one source byte
//   per item, with end_of_input set on the final byte of a source.
//   Output channel (o_out_valid / i_out_stall / o_out_data) gives tokens,
//   literal characters and unknown-byte items; last marks the final item
//   caused by one input byte. A byte that causes nothing sends nothing.
//   One byte is taken per cycle while the queue has room; the scanner state
//   is updated in the cycle a byte is taken.
//   Items leave at one per cycle while i_out_stall is low. The first item
//   of a byte passes the queue, the bundle register and the output register.
//   A long word can cause up to KEYWORD_MAX_LEN + 3 items; bursts wait in
//   a queue of QUEUE_DEPTH bundles, and o_in_stall rises when it is full.
//   When i_out_stall is high the output item holds, the sender stops and
//   the queue fills; then the input stalls.
//   Reset (i_rst_n low, synchronous) returns the scanner to idle, clears
//   pending operators, held hash and include flags, and empties the queue.
`default_nettype none
module c_subset_lexer #(
    parameter int KEYWORD_MAX_LEN = clx_pkg::KW_MAX_DEFAULT,
    parameter int QUEUE_DEPTH     = clx_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire clx_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output clx_pkg::t_out      o_out_data
);
    import clx_pkg::*;

    localparam int CW = cmd_bits(KEYWORD_MAX_LEN);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic [CW-1:0] cmd_in;
    logic [CW-1:0] cmd_out;

    clx_front #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
        .CW             (CW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_data (i_in_data),
        .o_in_stall(o_in_stall),
        .i_full    (full),
        .o_push    (push),
        .o_cmd     (cmd_in)
    );

    clx_fifo #(
        .W    (CW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (cmd_in),
        .i_pop  (pop),
        .o_data (cmd_out),
        .o_full (full),
        .o_empty(empty)
    );

    clx_back #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
        .CW             (CW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (!empty),
        .i_cmd      (cmd_out),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );
endmodule
`default_nettype wire

@@ tb/tb_c_subset_lexer.sv @@
// Testbench for the C subset lexer: directed byte table, then random source text.
// Depends on clx_pkg and c_subset_lexer; tokens are predicted by a local scanner model.
`timescale 1ns / 1ps
module tb_c_subset_lexer;
    import clx_pkg::*;

    localparam int KW_LEN = 7;
    localparam int WATCH_LIMIT = 20000;

    typedef enum logic [2:0] {
        SM_IDLE, SM_WORD, SM_STRING, SM_CHARVAL, SM_CHARCLOSE, SM_OPER
    } t_scan;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    t_in   in_data = '0;
    logic  out_valid;
    logic  out_stall = 1'b1;
    t_out  out_data;

    c_subset_lexer dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // scanner model state
    t_scan      sc_mode;
    logic [7:0] sc_buf [KW_LEN];
    int         sc_len;
    bit         sc_ovf;
    logic [1:0] sc_op;
    bit         sc_hash, sc_incl, sc_hdr;
    t_out       step_res [$];
    t_out       expected_items [$];
    int         fail_count = 0;
    bit         long_hold = 1'b0;
    bit         hold_on = 1'b0;
    bit         stim_done = 1'b0;

    function automatic bit is_alnum(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void put(logic [1:0] k, logic [5:0] code, logic [7:0] ch);
        t_out r;
        r.item_kind = k; r.token_code = code; r.char_value = ch; r.last = 1'b0;
        if (step_res.size() < 10) step_res.push_back(r);
    endfunction

    function automatic void put_token(logic [5:0] code);
        put(KIND_TOKEN, code, 8'd0);
        sc_incl = 1'b0;
    endfunction

    function automatic void drop_hash();
        if (sc_hash) begin
            sc_hash = 1'b0;
            put_token(TK_HASH);
        end
    endfunction

    function automatic void word_push(logic [7:0] c);
        if (sc_ovf) put(KIND_LIT, TK_IDENT, c);
        else if (sc_len < KW_LEN) begin
            sc_buf[sc_len] = c;
            sc_len++;
        end else begin
            drop_hash();
            for (int k = 0; k < sc_len; k++) put(KIND_LIT, TK_IDENT, sc_buf[k]);
            put(KIND_LIT, TK_IDENT, c);
            sc_ovf = 1'b1;
        end
    endfunction

    function automatic logic [5:0] word_code();
        string s;
        s = "";
        for (int k = 0; k < sc_len; k++) s = {s, string'(sc_buf[k])};
        case (s)
            "int":     return TK_INT;
            "void":    return TK_VOID;
            "if":      return TK_IF;
            "else":    return TK_ELSE;
            "while":   return TK_WHILE;
            "for":     return TK_FOR;
            "return":  return TK_RETURN;
            "include": return TK_INCLUDE;
            default:   return TK_IDENT;
        endcase
    endfunction

    function automatic void word_end();
        logic [5:0] code;
        if (sc_ovf) put_token(TK_IDENT);
        else begin
            code = word_code();
            if (code == TK_INCLUDE && sc_hash) begin
                sc_hash = 1'b0;
                put_token(TK_INCLUDE);
                sc_incl = 1'b1;
            end else begin
                drop_hash();
                if (code != TK_IDENT && code != TK_INCLUDE) put_token(code);
                else begin
                    for (int k = 0; k < sc_len; k++) put(KIND_LIT, TK_IDENT, sc_buf[k]);
                    put_token(TK_IDENT);
                end
            end
        end
        sc_len = 0;
        sc_ovf = 1'b0;
        sc_mode = SM_IDLE;
    endfunction

    function automatic logic [5:0] op_code(logic [1:0] op, bit dbl);
        logic [5:0] base;
        case (op)
            OP_BANG: base = TK_BANG;
            OP_LT:   base = TK_BANG + 6'd2;
            OP_GT:   base = TK_BANG + 6'd4;
            default: base = TK_BANG + 6'd6;
        endcase
        return dbl ? base + 6'd1 : base;
    endfunction

    function automatic void op_start(logic [1:0] op);
        sc_op = op;
        sc_mode = SM_OPER;
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic [5:0] p;
        sc_mode = SM_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) return;
        if (is_alnum(c)) begin
            sc_mode = SM_WORD;
            sc_len = 0;
            sc_ovf = 1'b0;
            word_push(c);
            return;
        end
        drop_hash();
        p = punct_code(c);
        if (p != TK_IDENT) put_token(p);
        else case (c)
            "#": sc_hash = 1'b1;
            "!": op_start(OP_BANG);
            "<": begin
                if (sc_incl) begin
                    sc_incl = 1'b0;
                    sc_hdr = 1'b1;
                end else op_start(OP_LT);
            end
            ">": begin
                if (sc_hdr) sc_hdr = 1'b0;
                else op_start(OP_GT);
            end
            "=": op_start(OP_EQ);
            "\"": sc_mode = SM_STRING;
            "'": sc_mode = SM_CHARVAL;
            default: put(KIND_ERR, TK_IDENT, c);
        endcase
    endfunction

    function automatic void lexer_reset();
        sc_mode = SM_IDLE; sc_len = 0; sc_ovf = 1'b0; sc_op = OP_BANG;
        sc_hash = 1'b0; sc_incl = 1'b0; sc_hdr = 1'b0;
    endfunction

    // Work out the items caused by one byte and queue them.
    function automatic void lex_byte(t_in d);
        logic [7:0] c;
        c = d.char_in;
        step_res.delete();
        case (sc_mode)
            SM_WORD: begin
                if (is_alnum(c) || c == "_") word_push(c);
                else begin
                    word_end();
                    scan_byte(c);
                end
            end
            SM_STRING: begin
                if (c == "\"") begin
                    put_token(TK_STRING);
                    sc_mode = SM_IDLE;
                end else put(KIND_LIT, TK_STRING, c);
            end
            SM_CHARVAL: begin
                put(KIND_LIT, TK_CHAR, c);
                put_token(TK_CHAR);
                sc_mode = SM_CHARCLOSE;
            end
            SM_CHARCLOSE: sc_mode = SM_IDLE;
            SM_OPER: begin
                if (c == "=") begin
                    put_token(op_code(sc_op, 1'b1));
                    sc_mode = SM_IDLE;
                end else begin
                    put_token(op_code(sc_op, 1'b0));
                    scan_byte(c);
                end
            end
            default: scan_byte(c);
        endcase
        if (d.end_of_input) begin
            case (sc_mode)
                SM_WORD:    word_end();
                SM_STRING:  put_token(TK_STRING);
                SM_CHARVAL: put_token(TK_CHAR);
                SM_OPER:    put_token(op_code(sc_op, 1'b0));
                default: ;
            endcase
            drop_hash();
            lexer_reset();
        end
        if (step_res.size() > 0) step_res[$].last = 1'b1;
        foreach (step_res[i]) expected_items.push_back(step_res[i]);
    endfunction

    // Directed rows: byte, eoi, and for a few rows a typed-in single expected item.
    typedef struct {
        logic [7:0] ch;
        bit         eoi;
        bit         typed;
        t_out       want;
    } t_row;

    t_row rows [$];

    function automatic void row(logic [7:0] ch, bit eoi);
        t_row r;
        r.ch = ch; r.eoi = eoi; r.typed = 1'b0; r.want = '0;
        rows.push_back(r);
    endfunction

    function automatic void row_typed(logic [7:0] ch, bit eoi, logic [1:0] k,
                                      logic [5:0] code, logic [7:0] v);
        t_row r;
        r.ch = ch; r.eoi = eoi; r.typed = 1'b1;
        r.want.item_kind = k; r.want.token_code = code; r.want.char_value = v;
        r.want.last = 1'b1;
        rows.push_back(r);
    endfunction

    function automatic void row_text(string s, bit eoi_at_end);
        for (int i = 0; i < s.len(); i++) row(s[i], eoi_at_end && i == s.len() - 1);
    endfunction

    task automatic send_byte(t_in d);
        in_data <= d;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        lex_byte(d);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    string frags [$] = '{"int ", "void", "if(", "else{", "while", "for;", "return ",
        "#include <stdio.h>\n", "# include<a>", "#define", "#(", "a!=b", "x<=y", "p>=q",
        "c==d", "e=f", "!g", "<>", "\"str x\"", "'a'", "'\"'", "longidentifier_x ",
        "abc_d1", "_bad", "[1],", "{}.+-*/", "x $ @", "\t\r\n", "includes", "if=="};

    task automatic random_source(int count);
        t_in d;
        string s;
        int pos;
        pos = 0;
        s = "";
        for (int i = 0; i < count; i++) begin
            if (pos >= s.len()) begin
                s = frags[$urandom_range(0, frags.size() - 1)];
                pos = 0;
            end
            if ($urandom_range(0, 9) == 0) d.char_in = 8'($urandom);
            else d.char_in = s[pos];
            pos++;
            d.end_of_input = ($urandom_range(0, 29) == 0);
            send_byte(d);
            sender_gap();
        end
    endtask

    initial begin
        t_in d;
        lexer_reset();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        row_typed("(", 1'b0, KIND_TOKEN, 6'd12, 8'd0);
        row_typed("/", 1'b0, KIND_TOKEN, 6'd24, 8'd0);
        row_typed(8'h00, 1'b0, KIND_ERR, TK_IDENT, 8'h00);
        row_typed(8'hff, 1'b0, KIND_ERR, TK_IDENT, 8'hff);
        row_typed("_", 1'b0, KIND_ERR, TK_IDENT, "_");
        row_typed("#", 1'b1, KIND_TOKEN, TK_HASH, 8'd0);
        row_typed("=", 1'b1, KIND_TOKEN, TK_BANG + 6'd6, 8'd0);
        row_text("!=<", 1'b0);
        row_text("=", 1'b0);
        row_text("#include<a>", 1'b0);
        row_text(" return abcdefghi\"s\"'x'y==", 1'b1);
        row_text("\"op", 1'b1);
        row_text("'", 1'b1);
        row_text("while1", 1'b1);

        foreach (rows[i]) begin
            d.char_in = rows[i].ch;
            d.end_of_input = rows[i].eoi;
            send_byte(d);
            if (rows[i].typed && (step_res.size() != 1 || step_res[0] != rows[i].want)) begin
                $display("%0t: table row %0d expected %p, model gives %p", $time, i,
                         rows[i].want, step_res.size() ? step_res[0] : '0);
                fail_count++;
            end
            sender_gap();
        end

        // long receiver hold while bytes keep coming
        long_hold = 1'b1;
        wait (hold_on);
        random_source(30);
        long_hold = 1'b0;
        in_valid <= 1'b0;
        while (expected_items.size() != 0) @(negedge clk);
        random_source(270);
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: stalls of random length, plus one long hold
    initial begin
        int n;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (long_hold) begin
                out_stall <= 1'b1;
                hold_on = 1'b1;
                repeat (200) @(negedge clk);
                while (long_hold) begin
                    out_stall <= 1'b0;
                    @(negedge clk);
                end
            end
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) n = 0;
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    always @(posedge clk) begin
        t_out e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_items.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %p", $time, out_data);
                fail_count++;
            end else begin
                e = expected_items.pop_front();
                if (out_data.item_kind != e.item_kind || out_data.token_code != e.token_code ||
                    out_data.char_value != e.char_value || out_data.last != e.last) begin
                    $display("%0t: mismatch, expected %p, got %p", $time, e, out_data);
                    fail_count++;
                end
            end
        end
    end

    // watchdog and end of run
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
            else idle++;
            if (stim_done && expected_items.size() == 0) begin
                repeat (20) @(posedge clk);
                if (fail_count == 0 && expected_items.size() == 0)
                    $display("** c_subset_lexer: PASSED **");
                else
                    $display("** c_subset_lexer: FAILED **");
                $finish;
            end
            if (idle >= WATCH_LIMIT) begin
                $display("%0t: no progress, %0d items still expected", $time,
                         expected_items.size());
                $display("** c_subset_lexer: FAILED **");
                $finish;
            end
        end
    end

endmodule

@@ c_subset_lexer.f @@
rtl/core/clx_pkg.sv
rtl/core/clx_fifo.sv
rtl/core/clx_front.sv
rtl/core/clx_back.sv
rtl/core/c_subset_lexer.sv
tb/tb_c_subset_lexer.sv
